FILE: rtl/itoa_pkg.sv
// Shared types and constants for the signed integer to decimal ASCII converter.
`default_nettype none

package itoa_pkg;

  // Input integer width and the number of decimal digits its magnitude can need.
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned NumDigits  = 10;
  localparam int unsigned BcdWidth   = 4 * NumDigits;
  localparam int unsigned CntWidth   = $clog2(ValueWidth);
  localparam int unsigned LeftWidth  = $clog2(NumDigits + 1);
  localparam int unsigned CharWidth  = 6;

  // Character codes, truncated to the six-bit output field.
  localparam logic [CharWidth-1:0] CharMinus = 6'd45;
  localparam logic [1:0]           CharDigitHi = 2'b11;  // '0' is 48 = 6'b11_0000

  // Top-level sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

  // Request from the sequencer to the binary-to-BCD converter.
  typedef struct packed {
    logic                  start;
    logic [ValueWidth-1:0] mag;
  } conv_req_t;

  // Status from the converter back to the sequencer.
  typedef struct packed {
    logic done;
  } conv_sts_t;

endpackage

`default_nettype wire

FILE: rtl/itoa_dabble.sv
// Bit-serial binary-to-BCD converter using the shift-and-add-three method.
`default_nettype none

module itoa_dabble (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire itoa_pkg::conv_req_t             req,
  output      itoa_pkg::conv_sts_t             sts,
  output      logic [itoa_pkg::BcdWidth-1:0]   bcd
);

  localparam logic [itoa_pkg::CntWidth-1:0] LastCnt =
    itoa_pkg::CntWidth'(itoa_pkg::ValueWidth - 1);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [itoa_pkg::CntWidth-1:0]     cnt_r, cnt_nxt;
  logic [itoa_pkg::ValueWidth-1:0]   mag_r, mag_nxt;
  logic [itoa_pkg::BcdWidth-1:0]     bcd_r, bcd_nxt;
  logic [itoa_pkg::BcdWidth-1:0]     bcd_adj;

  // Each BCD digit of five or more gets three added before the shift.
  always_comb begin
    for (int i = 0; i < itoa_pkg::NumDigits; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = 4'(bcd_r[4*i +: 4] + 4'd3);
      end else begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  // One magnitude bit moves into the BCD register each busy cycle.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    mag_nxt  = mag_r;
    bcd_nxt  = bcd_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      mag_nxt  = req.mag;
      bcd_nxt  = '0;
    end else if (busy_r) begin
      bcd_nxt = {bcd_adj[itoa_pkg::BcdWidth-2:0], mag_r[itoa_pkg::ValueWidth-1]};
      mag_nxt = {mag_r[itoa_pkg::ValueWidth-2:0], 1'b0};
      cnt_nxt = cnt_r + itoa_pkg::CntWidth'(1);
      if (cnt_r == LastCnt) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Data shift registers.
  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
  end

  assign sts.done = done_r;
  assign bcd      = bcd_r;

endmodule

`default_nettype wire

FILE: rtl/signed_int_to_decimal_ascii.sv
// Top level: converts a signed 32-bit integer into its decimal ASCII characters.
`default_nettype none

// Accepts one signed 32-bit value and returns its decimal text, most significant
// character first, one character per result item, with is_last set on the final
// character; negative values start with '-', zero gives a single '0'. The
// magnitude goes through a bit-serial shift-and-add-three converter, after which
// leading zero digits are dropped one per cycle (up to nine) and the characters
// leave one per cycle while the output is not stalled (one to eleven). Skipped
// zeros plus digits is always ten.
// in_stall stays high from acceptance until the last character is in the output
// register; a new value may be taken while that last character still waits.
module signed_int_to_decimal_ascii (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output      logic                             in_stall,
  input  wire logic signed [itoa_pkg::ValueWidth-1:0] in_value,
  output      logic                             out_valid,
  input  wire logic                             out_stall,
  output      logic [itoa_pkg::CharWidth-1:0]   out_text_char,
  output      logic                             out_is_last
);

  localparam logic [itoa_pkg::LeftWidth-1:0] AllDigits =
    itoa_pkg::LeftWidth'(itoa_pkg::NumDigits);
  localparam logic [itoa_pkg::LeftWidth-1:0] OneDigit =
    itoa_pkg::LeftWidth'(1);

  itoa_pkg::state_t                  state_r, state_nxt;
  itoa_pkg::conv_req_t               conv_req;
  itoa_pkg::conv_sts_t               conv_sts;
  logic [itoa_pkg::BcdWidth-1:0]     conv_bcd;

  logic                              neg_r;
  logic [itoa_pkg::BcdWidth-1:0]     dig_r;
  logic [itoa_pkg::LeftWidth-1:0]    left_r;
  logic                              out_valid_r;
  logic [itoa_pkg::CharWidth-1:0]    out_char_r;
  logic                              out_last_r;

  logic [itoa_pkg::ValueWidth-1:0]   raw;
  logic                              out_free;
  logic                              top_zero;
  logic                              more_left;
  logic                              accept;
  logic                              load_dig;
  logic                              skip_dig;
  logic                              emit_sign;
  logic                              emit_dig;

  assign raw       = in_value;
  assign out_free  = !out_valid_r || !out_stall;
  assign top_zero  = (dig_r[itoa_pkg::BcdWidth-1 -: 4] == 4'd0);
  assign more_left = (left_r != OneDigit);

  // Binary-to-BCD converter.
  assign conv_req.start = accept;
  assign conv_req.mag   = raw[itoa_pkg::ValueWidth-1] ? (32'd0 - raw) : raw;

  itoa_dabble u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (conv_req),
    .sts   (conv_sts),
    .bcd   (conv_bcd)
  );

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      itoa_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = itoa_pkg::ST_CONV;
      end
      itoa_pkg::ST_CONV: begin
        if (conv_sts.done) state_nxt = itoa_pkg::ST_SKIP;
      end
      itoa_pkg::ST_SKIP: begin
        if (!(top_zero && more_left)) begin
          state_nxt = neg_r ? itoa_pkg::ST_SIGN : itoa_pkg::ST_EMIT;
        end
      end
      itoa_pkg::ST_SIGN: begin
        if (out_free) state_nxt = itoa_pkg::ST_EMIT;
      end
      itoa_pkg::ST_EMIT: begin
        if (out_free && !more_left) state_nxt = itoa_pkg::ST_IDLE;
      end
      default: state_nxt = itoa_pkg::ST_IDLE;
    endcase
  end

  // State-dependent controls.
  always_comb begin
    in_stall  = 1'b1;
    accept    = 1'b0;
    load_dig  = 1'b0;
    skip_dig  = 1'b0;
    emit_sign = 1'b0;
    emit_dig  = 1'b0;
    unique case (state_r)
      itoa_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
      end
      itoa_pkg::ST_CONV: load_dig  = conv_sts.done;
      itoa_pkg::ST_SKIP: skip_dig  = top_zero && more_left;
      itoa_pkg::ST_SIGN: emit_sign = out_free;
      itoa_pkg::ST_EMIT: emit_dig  = out_free;
      default: in_stall = 1'b1;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itoa_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit_sign || emit_dig) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Sign, digit shift register and output payload.
  always_ff @(posedge clk) begin
    if (accept) neg_r <= raw[itoa_pkg::ValueWidth-1];
    if (load_dig) begin
      dig_r  <= conv_bcd;
      left_r <= AllDigits;
    end else if (skip_dig || emit_dig) begin
      dig_r  <= {dig_r[itoa_pkg::BcdWidth-5:0], 4'd0};
      left_r <= left_r - OneDigit;
    end
    if (emit_sign) begin
      out_char_r <= itoa_pkg::CharMinus;
      out_last_r <= 1'b0;
    end else if (emit_dig) begin
      out_char_r <= {itoa_pkg::CharDigitHi, dig_r[itoa_pkg::BcdWidth-1 -: 4]};
      out_last_r <= !more_left;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_text_char = out_char_r;
  assign out_is_last   = out_last_r;

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Testbench for the signed integer to decimal ASCII converter, with a self-checking predictor.
`timescale 1ns / 100ps

module tb_top;

  // One predicted character of a number's text.
  typedef struct {
    logic [itoa_pkg::CharWidth-1:0] text_char;
    logic                           is_last;
  } text_char_t;

  localparam logic [itoa_pkg::CharWidth-1:0] CharZero = {itoa_pkg::CharDigitHi, 4'b0000};
  localparam int unsigned          IdleLimit = 4000;
  localparam int unsigned          LongHold  = 300;

  logic                                   clk;
  logic                                   rst_n;
  logic                                   in_valid;
  logic                                   in_stall;
  logic signed [itoa_pkg::ValueWidth-1:0] in_value;
  logic                                   out_valid;
  logic                                   out_stall;
  logic [itoa_pkg::CharWidth-1:0]         out_text_char;
  logic                                   out_is_last;

  text_char_t  text_expected[$];
  int unsigned values_sent;
  int unsigned chars_checked;
  int unsigned mismatches;
  int unsigned idle_cycles;
  int unsigned hold_len_req;
  bit          tx_gaps_on;
  bit          rx_stall_on;

  signed_int_to_decimal_ascii dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_text_char(out_text_char),
    .out_is_last  (out_is_last)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap length: mostly none, sometimes a few cycles, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Works out the characters of one value: sign first, then digits, most significant first.
  function automatic void predict_decimal_text(input logic [itoa_pkg::ValueWidth-1:0] value);
    logic [itoa_pkg::ValueWidth-1:0] mag;
    logic [3:0]                      digits[$];
    text_char_t                      ch;
    mag = value[itoa_pkg::ValueWidth-1] ? -value : value;
    do begin
      digits.push_front(4'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (value[itoa_pkg::ValueWidth-1]) begin
      ch.text_char = itoa_pkg::CharMinus;
      ch.is_last   = 1'b0;
      text_expected.push_back(ch);
    end
    foreach (digits[i]) begin
      ch.text_char = CharZero + itoa_pkg::CharWidth'(digits[i]);
      ch.is_last   = (i == digits.size() - 1);
      text_expected.push_back(ch);
    end
  endfunction

  // Offers one item and waits for it to be taken; valid stays high when no gap follows.
  task automatic send_value(input logic [itoa_pkg::ValueWidth-1:0] value);
    int unsigned gap;
    in_valid <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (in_stall);
    predict_decimal_text(value);
    values_sent++;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering items and waits until every predicted character has arrived.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (text_expected.size() != 0) @(posedge clk);
  endtask

  // Field extremes, all-ones and alternating patterns, zero and the most negative value.
  task automatic test_directed_values();
    logic [itoa_pkg::ValueWidth-1:0] values[$];
    tx_gaps_on  = 1'b0;
    rx_stall_on = 1'b0;
    values = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
               32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
               32'd999999999, -32'sd999999999, 32'd1234567890, -32'sd1234567890,
               32'h5555_5555, 32'hAAAA_AAAA, 32'd2000000000, -32'sd2000000001,
               32'd1020304050, -32'sd7};
    foreach (values[i]) send_value(values[i]);
    wait_for_drain();
  endtask

  // Powers of ten and one below them, each with a random sign.
  task automatic test_decade_boundaries();
    longint unsigned pow;
    logic [itoa_pkg::ValueWidth-1:0] mag;
    tx_gaps_on  = 1'b1;
    rx_stall_on = 1'b0;
    pow = 1;
    for (int k = 0; k < 10; k++) begin
      for (int j = 0; j < 2; j++) begin
        mag = itoa_pkg::ValueWidth'(pow - j);
        send_value($urandom_range(0, 1) ? -mag : mag);
      end
      pow = pow * 10;
    end
    wait_for_drain();
  endtask

  // Random values with an evenly spread digit count and random sign.
  task automatic test_digit_lengths(input int unsigned count);
    longint unsigned lo;
    longint unsigned hi;
    logic [itoa_pkg::ValueWidth-1:0] mag;
    int unsigned ndig;
    tx_gaps_on  = 1'b1;
    rx_stall_on = 1'b1;
    repeat (count) begin
      ndig = $urandom_range(1, 10);
      lo = 1;
      repeat (ndig - 1) lo = lo * 10;
      hi = lo * 10 - 1;
      if (ndig == 1) lo = 0;
      if (hi > 64'h7FFF_FFFF) hi = 64'h7FFF_FFFF;
      mag = itoa_pkg::ValueWidth'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
      send_value($urandom_range(0, 1) ? -mag : mag);
    end
    wait_for_drain();
  endtask

  // Values drawn from the whole 32-bit range.
  task automatic test_full_range(input int unsigned count);
    tx_gaps_on  = 1'b1;
    rx_stall_on = 1'b1;
    repeat (count) send_value($urandom);
    wait_for_drain();
  endtask

  // A long receiver hold with back-to-back items, then random stalls and input gaps.
  task automatic test_output_backpressure(input int unsigned count);
    tx_gaps_on   = 1'b0;
    rx_stall_on  = 1'b0;
    hold_len_req = LongHold;
    repeat (count) send_value($urandom);
    wait_for_drain();
    rx_stall_on = 1'b1;
    tx_gaps_on  = 1'b1;
    repeat (count) send_value($urandom);
    wait_for_drain();
  endtask

  // Receiver stall: an optional long hold on request, otherwise random short stalls.
  initial begin
    int unsigned hold_len;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len_req > 0) begin
        hold_len     = hold_len_req;
        hold_len_req = 0;
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_stall_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat (pick_gap() + 1) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted character with the oldest prediction.
  always @(posedge clk) begin
    text_char_t exp_ch;
    if (rst_n && out_valid && !out_stall) begin
      chars_checked++;
      if (text_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: unexpected character %0d is_last %0d",
                   out_text_char, out_is_last);
        end
      end else begin
        exp_ch = text_expected.pop_front();
        if (out_text_char !== exp_ch.text_char || out_is_last !== exp_ch.is_last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: character expected %0d/%0d got %0d/%0d (char/is_last)",
                     exp_ch.text_char, exp_ch.is_last, out_text_char, out_is_last);
          end
        end
      end
    end
  end

  // Watchdog: too long without any item moving on either side ends the run.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("ERROR: no progress for %0d cycles", IdleLimit);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_value      = '0;
    values_sent   = 0;
    chars_checked = 0;
    mismatches    = 0;
    idle_cycles   = 0;
    hold_len_req  = 0;
    tx_gaps_on    = 1'b0;
    rx_stall_on   = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_values();
    test_decade_boundaries();
    test_digit_lengths(35);
    test_full_range(35);
    test_output_backpressure(6);

    // Give any stray characters time to show up.
    repeat (80) @(posedge clk);
    $display("Converted %0d values into %0d checked characters, with idle gaps,",
             values_sent, chars_checked);
    $display("random output stalls and one long output hold; %0d mismatches.", mismatches);
    if (mismatches == 0 && text_expected.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/itoa_pkg.sv
rtl/itoa_dabble.sv
rtl/signed_int_to_decimal_ascii.sv
tb/sv/tb_top.sv
